@@ sv/lfu_pkg.sv @@
// lfu_pkg: shared constants, types and helper functions for the LFU cache directory.
// No dependencies; imported by lfu_ctrl and lfu_cache_directory_top.
package lfu_pkg;

  // Built geometry
  localparam int ENTRIES    = 128;
  localparam int KEY_BITS   = 64;
  localparam int COUNT_BITS = 32;

  // Derived widths
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ACT_W  = 8;
  localparam int KEY_IN_W = 64;
  localparam int LEN_W  = 32;
  localparam int SLOT_W = 7;

  localparam logic [ACT_W-1:0]      ACTIVE_RST = ACT_W'(128);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  // One directory row as held in the entry memory
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [LEN_W-1:0]      length;
    logic [LEN_W-1:0]      handle;
    logic [COUNT_BITS-1:0] count;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Result beat
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  handle;
  } result_t;

  // Memory port controls
  typedef struct packed {
    logic             re;
    logic             we;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
  } ram_ctl_t;

  // Active count clamped to 1..ENTRIES
  function automatic logic [CNT_W-1:0] live_slots(input logic [ACT_W-1:0] active);
    logic [CNT_W-1:0] n;
    if (active == '0) begin
      n = CNT_W'(1);
    end else if (32'(active) > ENTRIES) begin
      n = CNT_W'(ENTRIES);
    end else begin
      n = CNT_W'(active);
    end
    return n;
  endfunction

  // Slot number as reported: low 7 bits of the index
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[SLOT_W-1:0];
  endfunction

endpackage

@@ sv/lfu_ram.sv @@
// lfu_ram: generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lfu_ctrl.sv @@
// lfu_ctrl: directory sequencer. Scans the entry memory one row per cycle for lookups
// and victim selection, does the read-modify-write, keeps valid bits and fill pointer.
// Depends on lfu_pkg.
module lfu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lfu_pkg::ACT_W-1:0]   active,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [lfu_pkg::KEY_BITS-1:0] in_key,
  input  logic [lfu_pkg::LEN_W-1:0]   in_length,
  input  logic [lfu_pkg::LEN_W-1:0]   in_handle,
  output lfu_pkg::ram_ctl_t           ram_ctl,
  output logic [lfu_pkg::ROW_W-1:0]   ram_wdata,
  input  logic [lfu_pkg::ROW_W-1:0]   ram_rdata,
  output logic                        res_valid,
  output lfu_pkg::result_t            res,
  input  logic                        res_take
);
  import lfu_pkg::*;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      hdl_r, hdl_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  logic [IDX_W-1:0]      wr_addr_r, wr_addr_nxt;
  logic [COUNT_BITS-1:0] wr_cnt_r, wr_cnt_nxt;
  result_t               res_r, res_nxt;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;

  row_t                  q;
  row_t                  wrow;
  logic                  ent_valid;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic [CNT_W-1:0]      live;

  assign q         = row_t'(ram_rdata);
  assign ent_valid = valid_r[cmp_idx_r];
  // never-written rows count as zero
  assign ent_cnt   = ent_valid ? q.count : '0;
  assign live      = live_slots(active);

  // Row written back: insert stores the new item, a hit rewrites with the bumped count
  always_comb begin
    wrow.key    = key_r;
    wrow.length = (op_r == OP_INSERT) ? len_r : res_r.length;
    wrow.handle = (op_r == OP_INSERT) ? hdl_r : res_r.handle;
    wrow.count  = wr_cnt_r;
  end
  assign ram_wdata = wrow;

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    len_nxt      = len_r;
    hdl_nxt      = hdl_r;
    n_nxt        = n_r;
    fill_nxt     = fill_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    wr_addr_nxt  = wr_addr_r;
    wr_cnt_nxt   = wr_cnt_r;
    res_nxt      = res_r;
    valid_nxt    = valid_r;
    ram_ctl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_op);
          key_nxt    = in_key;
          len_nxt    = in_length;
          hdl_nxt    = in_handle;
          n_nxt      = live;
          rd_idx_nxt = '0;
          res_nxt    = '0;
          wr_cnt_nxt = '0;
          if ((op_t'(in_op) == OP_INSERT) && (fill_r < live)) begin
            // still filling: next free slot, no scan
            wr_addr_nxt = fill_r[IDX_W-1:0];
            fill_nxt    = CNT_W'(fill_r + 1'b1);
            state_nxt   = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue the next row read
        if (rd_idx_r < n_r) begin
          ram_ctl.re    = 1'b1;
          ram_ctl.raddr = rd_idx_r[IDX_W-1:0];
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt    = CNT_W'(rd_idx_r + 1'b1);
        end
        // check the row read last cycle
        if (cmp_vld_r) begin
          if (op_r == OP_LOOKUP) begin
            if (ent_valid && (q.key == key_r)) begin
              res_nxt.hit    = 1'b1;
              res_nxt.slot   = to_slot(cmp_idx_r);
              res_nxt.length = q.length;
              res_nxt.handle = q.handle;
              wr_addr_nxt    = cmp_idx_r;
              wr_cnt_nxt     = (q.count == COUNT_MAX) ? q.count
                                                      : COUNT_BITS'(q.count + 1'b1);
              cmp_vld_nxt    = 1'b0;
              state_nxt      = ST_WRITE;
            end
          end else begin
            // ties go to the higher slot
            if ((cmp_idx_r == '0) || (ent_cnt <= best_cnt_r)) begin
              best_idx_nxt = cmp_idx_r;
              best_cnt_nxt = ent_cnt;
            end
          end
        end else if (rd_idx_r >= n_r) begin
          // every live row checked
          if (op_r == OP_LOOKUP) begin
            state_nxt = ST_DONE;
          end else begin
            wr_addr_nxt = best_idx_r;
            wr_cnt_nxt  = '0;
            state_nxt   = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        ram_ctl.we           = 1'b1;
        ram_ctl.waddr        = wr_addr_r;
        valid_nxt[wr_addr_r] = 1'b1;
        res_nxt.slot         = to_slot(wr_addr_r);
        state_nxt            = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    hdl_r      <= hdl_nxt;
    n_r        <= n_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_cnt_r   <= wr_cnt_nxt;
    res_r      <= res_nxt;
  end

  // A written row is valid from the next cycle on
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.we |=> valid_r[$past(ram_ctl.waddr)])
    else $error("written row not marked valid");

  // Fill pointer never passes the built depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= ENTRIES)
    else $error("fill pointer out of range");

  // Fill pointer only steps by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (fill_r == CNT_W'($past(fill_r) + 1'b1)))
    else $error("fill pointer jumped");

  // Only lookups report a hit
  a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.hit) |-> (op_r == OP_LOOKUP))
    else $error("insert reported a hit");

  // Scan read index stays within the live slots
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= n_r))
    else $error("scan index past live slots");

endmodule

@@ sv/lfu_cache_directory_top.sv @@
// Path to out_valid: a fill insert goes to ST_WRITE with no scan; a lookup scans the
// live slots one row per cycle and writes a hit back in ST_WRITE; a replacing insert scans
// them all, then writes the victim; all end in ST_DONE, then move to the output register.
// One item at a time; the next beat can be taken in the cycle after the result moves into the
// output register. Reset clears valid bits, fill pointer and use counts (by valid bits);
// active_r returns to 128. No clearing pass. Depends on lfu_pkg, lfu_ram, lfu_ctrl.
module lfu_cache_directory_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lfu_pkg::ACT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [lfu_pkg::KEY_IN_W-1:0]  in_key,
  input  logic [lfu_pkg::LEN_W-1:0]     in_length,
  input  logic [lfu_pkg::LEN_W-1:0]     in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]    out_slot,
  output logic [lfu_pkg::LEN_W-1:0]     out_hit_length,
  output logic [lfu_pkg::LEN_W-1:0]     out_hit_handle
);
  import lfu_pkg::*;

  logic [ACT_W-1:0] active_r, active_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;

  ram_ctl_t         ram_ctl;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic             res_valid;
  result_t          res;
  logic             res_take;

  // Configuration register
  assign active_nxt = cfg_we ? cfg_wdata : active_r;

  // Entry memory
  lfu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_wdata),
    .re    (ram_ctl.re),
    .raddr (ram_ctl.raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .active    (active_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_key    (in_key[KEY_BITS-1:0]),
    .in_length (in_length),
    .in_handle (in_handle),
    .ram_ctl   (ram_ctl),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: loads when empty or its beat leaves this cycle
  always_comb begin
    res_take      = res_valid && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RST;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_r.hit;
  assign out_slot       = out_r.slot;
  assign out_hit_length = out_r.length;
  assign out_hit_handle = out_r.handle;

endmodule
